// ===== src/pcic_pkg.sv =====
`timescale 1ns / 1ps

package pcic_pkg;

  localparam int DATA_W = 32;
  localparam int DT_W   = 24;
  localparam int FRAC   = 16;
  localparam int PROD_W = 2 * (DATA_W + 1);

  // register index codes on the config port
  localparam logic [1:0] REG_GAIN_P = 2'd0;
  localparam logic [1:0] REG_GAIN_I = 2'd1;
  localparam logic [1:0] REG_GAIN_D = 2'd2;
  localparam logic [1:0] REG_BOUND  = 2'd3;

  typedef logic signed [DATA_W-1:0] q16_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // floor shift of a Q34.32 product back to Q16.16, saturated to 32 bits
  function automatic q16_t sat_shift(input prod_t p);
    prod_t t;
    prod_t hi;
    prod_t lo;
    hi = prod_t'(66'sd2147483647);
    lo = -prod_t'(66'sd2147483648);
    t  = p >>> FRAC;
    if (t > hi) begin
      return q16_t'(32'h7fff_ffff);
    end else if (t < lo) begin
      return q16_t'(32'h8000_0000);
    end else begin
      return t[DATA_W-1:0];
    end
  endfunction

endpackage

// ===== src/pid_controller_integral_clamp_top.sv =====
`timescale 1ns / 1ps

// PID step with clamped integral, signed Q16.16 data, unsigned Q8.16 time step.
// Input channel: in_valid / in_stall carry error_sample and time_step. A word is
// taken when in_valid is high and in_stall low. Output channel: out_valid /
// out_stall carry drive_value, held steady while out_stall is high.
// Config: cfg_write with cfg_index / cfg_data writes a gain or the integral bound;
// write only while the block is idle.
// Datapath: one shared 33x33 multiplier (product registered) and a radix-2
// restoring divider that retires one quotient bit per cycle. A word with a
// nonzero time step runs the integral multiply and clamped accumulate, then the
// proportional and integral terms, then one divide step per bit of the 49-bit
// derivative numerator, then the derivative term and output saturation.
// A zero time step returns 0 and leaves the state alone.
// One word is worked at a time; in_stall is high while busy.
// The finished result sits in an output register, so a new word is taken once
// the sequencer is back to idle even if out_stall holds the previous result;
// the sequencer waits in its final step only if that register is still full.
// Reset clears gains, bound, integral, previous error and out_valid.

module pid_controller_integral_clamp_top
  import pcic_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] error_sample,
  input  logic        [DT_W-1:0]   time_step,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] drive_value,
  input  logic                     cfg_write,
  input  logic [1:0]               cfg_index,
  input  logic [DATA_W-1:0]        cfg_data
);

  localparam int NUM_W = DATA_W + 1 + FRAC;   // |error diff| << 16
  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MUL_INT  = 4'd1;
  localparam logic [3:0] S_ACC      = 4'd2;
  localparam logic [3:0] S_MUL_P    = 4'd3;
  localparam logic [3:0] S_ADD_P    = 4'd4;
  localparam logic [3:0] S_MUL_I    = 4'd5;
  localparam logic [3:0] S_ADD_I    = 4'd6;
  localparam logic [3:0] S_DIV_INIT = 4'd7;
  localparam logic [3:0] S_DIV      = 4'd8;
  localparam logic [3:0] S_DIV_FIN  = 4'd9;
  localparam logic [3:0] S_MUL_D    = 4'd10;
  localparam logic [3:0] S_ADD_D    = 4'd11;
  localparam logic [3:0] S_OUT      = 4'd12;

  logic [3:0] state;

  q16_t gain_p, gain_i, gain_d;
  logic [DATA_W-2:0] integral_bound;
  q16_t integral_sum, last_error;

  q16_t err;
  logic [DT_W-1:0] dt;
  logic signed [DATA_W:0] diff;
  q16_t deriv;
  logic signed [DATA_W+1:0] sum;
  q16_t result;

  logic signed [DATA_W:0] mul_a, mul_b;
  prod_t prod;
  q16_t term;

  logic [NUM_W-1:0] div_num;
  logic [DT_W-1:0]  div_rem;
  logic             div_neg;
  logic [CNT_W-1:0] div_cnt;
  logic [DT_W+1:0]  trial;

  logic signed [DATA_W+9:0] acc;
  logic signed [DATA_W+9:0] bound_ext;
  logic signed [DATA_W+1:0] sum_next;
  logic [DATA_W:0] diff_mag;
  logic out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MUL_INT: begin
        mul_a = {err[DATA_W-1], err};
        mul_b = {{(DATA_W + 1 - DT_W){1'b0}}, dt};
      end
      S_MUL_P: begin
        mul_a = {gain_p[DATA_W-1], gain_p};
        mul_b = {err[DATA_W-1], err};
      end
      S_MUL_I: begin
        mul_a = {gain_i[DATA_W-1], gain_i};
        mul_b = {integral_sum[DATA_W-1], integral_sum};
      end
      S_MUL_D: begin
        mul_a = {gain_d[DATA_W-1], gain_d};
        mul_b = {deriv[DATA_W-1], deriv};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    prod_t sh;
    sh        = prod >>> FRAC;
    term      = sat_shift(prod);
    acc       = {{10{integral_sum[DATA_W-1]}}, integral_sum} + sh[DATA_W+9:0];
    bound_ext = {11'b0, integral_bound};
    sum_next  = sum + {{2{term[DATA_W-1]}}, term};
    diff_mag  = diff[DATA_W] ? 33'(-diff) : 33'(diff);
    trial     = {1'b0, div_rem, div_num[NUM_W-1]} - {2'b0, dt};
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state          <= S_IDLE;
      gain_p         <= '0;
      gain_i         <= '0;
      gain_d         <= '0;
      integral_bound <= '0;
      integral_sum   <= '0;
      last_error     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_GAIN_P: gain_p <= cfg_data;
          REG_GAIN_I: gain_i <= cfg_data;
          REG_GAIN_D: gain_d <= cfg_data;
          REG_BOUND:  integral_bound <= cfg_data[DATA_W-2:0];
          default: begin
          end
        endcase
      end

      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            err <= error_sample;
            dt  <= time_step;
            if (time_step == '0) begin
              result <= '0;
              state  <= S_OUT;
            end else begin
              diff       <= {error_sample[DATA_W-1], error_sample}
                            - {last_error[DATA_W-1], last_error};
              last_error <= error_sample;
              state      <= S_MUL_INT;
            end
          end
        end
        S_MUL_INT: state <= S_ACC;
        S_ACC: begin
          if (acc > bound_ext) begin
            integral_sum <= q16_t'({1'b0, integral_bound});
          end else if (acc < -bound_ext) begin
            integral_sum <= q16_t'(-{1'b0, integral_bound});
          end else begin
            integral_sum <= acc[DATA_W-1:0];
          end
          state <= S_MUL_P;
        end
        S_MUL_P: state <= S_ADD_P;
        S_ADD_P: begin
          sum   <= {{2{term[DATA_W-1]}}, term};
          state <= S_MUL_I;
        end
        S_MUL_I: state <= S_ADD_I;
        S_ADD_I: begin
          sum   <= sum_next;
          state <= S_DIV_INIT;
        end
        S_DIV_INIT: begin
          div_num <= {diff_mag, {FRAC{1'b0}}};
          div_neg <= diff[DATA_W];
          div_rem <= '0;
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          // quotient bits shift in at the bottom as numerator bits leave the top
          if (!trial[DT_W+1]) begin
            div_rem <= trial[DT_W-1:0];
            div_num <= {div_num[NUM_W-2:0], 1'b1};
          end else begin
            div_rem <= {div_rem[DT_W-2:0], div_num[NUM_W-1]};
            div_num <= {div_num[NUM_W-2:0], 1'b0};
          end
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == LAST_STEP) begin
            state <= S_DIV_FIN;
          end
        end
        S_DIV_FIN: begin
          if (div_neg) begin
            if ((|div_num[NUM_W-1:DATA_W]) ||
                (div_num[DATA_W-1] && (|div_num[DATA_W-2:0]))) begin
              deriv <= q16_t'(32'h8000_0000);
            end else begin
              deriv <= q16_t'(-div_num[DATA_W-1:0]);
            end
          end else begin
            if (|div_num[NUM_W-1:DATA_W-1]) begin
              deriv <= q16_t'(32'h7fff_ffff);
            end else begin
              deriv <= q16_t'(div_num[DATA_W-1:0]);
            end
          end
          state <= S_MUL_D;
        end
        S_MUL_D: state <= S_ADD_D;
        S_ADD_D: begin
          if (sum_next > 34'sd2147483647) begin
            result <= q16_t'(32'h7fff_ffff);
          end else if (sum_next < -34'sd2147483648) begin
            result <= q16_t'(32'h8000_0000);
          end else begin
            result <= sum_next[DATA_W-1:0];
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            drive_value <= result;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
